>>> hw/rtl/cia_pkg.sv
package cia_pkg;

    // keyboard columns that are stored and scanned (1 to 8)
    localparam int unsigned KEY_COLUMNS = 8;

    typedef enum logic [2:0] {
        CMD_READ     = 3'd0,
        CMD_WRITE    = 3'd1,
        CMD_TICK     = 3'd2,
        CMD_KEY_DOWN = 3'd3,
        CMD_KEY_UP   = 3'd4
    } cia_cmd_t;

    localparam logic [3:0] REG_PRA    = 4'h0;
    localparam logic [3:0] REG_PRB    = 4'h1;
    localparam logic [3:0] REG_DDRA   = 4'h2;
    localparam logic [3:0] REG_DDRB   = 4'h3;
    localparam logic [3:0] REG_TALO   = 4'h4;
    localparam logic [3:0] REG_TAHI   = 4'h5;
    localparam logic [3:0] REG_TBLO   = 4'h6;
    localparam logic [3:0] REG_TBHI   = 4'h7;
    localparam logic [3:0] REG_TENTHS = 4'h8;
    localparam logic [3:0] REG_SECS   = 4'h9;
    localparam logic [3:0] REG_MINS   = 4'hA;
    localparam logic [3:0] REG_HOURS  = 4'hB;
    localparam logic [3:0] REG_SDR    = 4'hC;
    localparam logic [3:0] REG_ICR    = 4'hD;
    localparam logic [3:0] REG_CRA    = 4'hE;
    localparam logic [3:0] REG_CRB    = 4'hF;

    // control register bits
    localparam int unsigned CR_START   = 0;
    localparam int unsigned CR_ONESHOT = 3;
    localparam int unsigned CR_LOAD    = 4;
    localparam int unsigned CRA_CNT    = 5;

    localparam logic [1:0] CRB_MODE_CLK = 2'b00;
    localparam logic [1:0] CRB_MODE_TA  = 2'b10;

    // interrupt status bits
    localparam int unsigned ISR_TA  = 0;
    localparam int unsigned ISR_TB  = 1;
    localparam int unsigned ISR_IRQ = 7;

    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  reg_addr;
        logic [7:0]  write_data;
        logic [15:0] elapsed_ticks;
        logic [2:0]  key_column;
        logic [2:0]  key_row;
    } cia_in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_raised;
    } cia_out_t;

endpackage

>>> hw/rtl/cia_keys.sv
module cia_keys (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step_valid,
    input  cia_pkg::cia_in_t item,
    input  logic [7:0]      pra,
    output logic [7:0]      scan_data
);

    logic [7:0] key_matrix_reg  [8];
    logic [7:0] key_matrix_next [8];
    logic [7:0] row_bit;
    logic       col_ok;

    assign row_bit = 8'(1) << item.key_row;
    assign col_ok  = {1'b0, item.key_column} < 4'(cia_pkg::KEY_COLUMNS);

    always_comb begin
        key_matrix_next = key_matrix_reg;
        if (step_valid && col_ok) begin
            if (item.command == cia_pkg::CMD_KEY_DOWN) begin
                key_matrix_next[item.key_column] = key_matrix_reg[item.key_column] & ~row_bit;
            end else if (item.command == cia_pkg::CMD_KEY_UP) begin
                key_matrix_next[item.key_column] = key_matrix_reg[item.key_column] | row_bit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                key_matrix_reg[i] <= 8'hff;
            end
        end else begin
            key_matrix_reg <= key_matrix_next;
        end
    end

    // a column is driven when its port A bit is low
    always_comb begin
        scan_data = 8'hff;
        for (int i = 0; i < 8; i++) begin
            if (i < int'(cia_pkg::KEY_COLUMNS) && !pra[i]) begin
                scan_data = scan_data & key_matrix_reg[i];
            end
        end
    end

endmodule

>>> hw/rtl/cia_regs.sv
module cia_regs (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_valid,
    input  cia_pkg::cia_in_t  item,
    input  logic [7:0]       scan_data,
    output logic [7:0]       pra,
    output cia_pkg::cia_out_t result
);

    logic [7:0]  pra_reg, pra_next;
    logic [7:0]  prb_reg, prb_next;
    logic [7:0]  ddra_reg, ddra_next;
    logic [7:0]  ddrb_reg, ddrb_next;
    logic [15:0] ta_reg, ta_next;
    logic [15:0] tb_reg, tb_next;
    logic [15:0] ta_latch_reg, ta_latch_next;
    logic [15:0] tb_latch_reg, tb_latch_next;
    logic [7:0]  tod_reg [4];
    logic [7:0]  tod_next [4];
    logic [7:0]  tod_latch_reg [4];
    logic [7:0]  tod_latch_next [4];
    logic [7:0]  sdr_reg, sdr_next;
    logic [6:0]  mask_reg, mask_next;
    logic [7:0]  cra_reg, cra_next;
    logic [7:0]  crb_reg, crb_next;
    logic [7:0]  status_reg, status_next;
    logic        hold_reg, hold_next;

    logic        ta_run, tb_run;
    logic        ta_borrow, tb_borrow;
    logic        ta_under, tb_under;
    logic [15:0] ta_diff, tb_diff;
    logic [15:0] tb_count;
    logic [1:0]  tod_idx;
    logic [7:0]  tod_view;
    logic [7:0]  rd;
    logic        irq;

    assign pra     = pra_reg;
    assign tod_idx = item.reg_addr[1:0];
    assign tod_view = hold_reg ? tod_latch_reg[tod_idx] : tod_reg[tod_idx];

    // timer A counts first; timer B may count its underflow in the same tick
    assign ta_run = cra_reg[cia_pkg::CR_START] && !cra_reg[cia_pkg::CRA_CNT];
    assign {ta_borrow, ta_diff} = {1'b0, ta_reg} - {1'b0, item.elapsed_ticks};
    assign ta_under = ta_run && ta_borrow;

    always_comb begin
        if (crb_reg[6:5] == cia_pkg::CRB_MODE_CLK) begin
            tb_count = item.elapsed_ticks;
        end else if (crb_reg[6:5] == cia_pkg::CRB_MODE_TA) begin
            tb_count = {15'd0, ta_under};
        end else begin
            tb_count = 16'd0;
        end
    end

    assign tb_run = crb_reg[cia_pkg::CR_START];
    assign {tb_borrow, tb_diff} = {1'b0, tb_reg} - {1'b0, tb_count};
    assign tb_under = tb_run && tb_borrow;

    always_comb begin
        pra_next       = pra_reg;
        prb_next       = prb_reg;
        ddra_next      = ddra_reg;
        ddrb_next      = ddrb_reg;
        ta_next        = ta_reg;
        tb_next        = tb_reg;
        ta_latch_next  = ta_latch_reg;
        tb_latch_next  = tb_latch_reg;
        tod_next       = tod_reg;
        tod_latch_next = tod_latch_reg;
        sdr_next       = sdr_reg;
        mask_next      = mask_reg;
        cra_next       = cra_reg;
        crb_next       = crb_reg;
        status_next    = status_reg;
        hold_next      = hold_reg;
        rd             = 8'd0;
        irq            = 1'b0;

        unique case (item.command)
            cia_pkg::CMD_READ: begin
                unique case (item.reg_addr)
                    cia_pkg::REG_PRA:  rd = pra_reg;
                    cia_pkg::REG_PRB:  rd = scan_data;
                    cia_pkg::REG_DDRA: rd = ddra_reg;
                    cia_pkg::REG_DDRB: rd = ddrb_reg;
                    cia_pkg::REG_TALO: rd = ta_reg[7:0];
                    cia_pkg::REG_TAHI: rd = ta_reg[15:8];
                    cia_pkg::REG_TBLO: rd = tb_reg[7:0];
                    cia_pkg::REG_TBHI: rd = tb_reg[15:8];
                    cia_pkg::REG_TENTHS: begin
                        rd        = tod_view;
                        hold_next = 1'b0;
                    end
                    cia_pkg::REG_SECS, cia_pkg::REG_MINS: rd = tod_view;
                    cia_pkg::REG_HOURS: begin
                        // snapshot all four and freeze until tenths is read
                        tod_latch_next = tod_reg;
                        hold_next      = 1'b1;
                        rd             = tod_reg[3];
                    end
                    cia_pkg::REG_SDR: rd = sdr_reg;
                    cia_pkg::REG_ICR: begin
                        rd          = status_reg;
                        status_next = 8'd0;
                    end
                    cia_pkg::REG_CRA: rd = cra_reg;
                    cia_pkg::REG_CRB: rd = crb_reg;
                endcase
            end
            cia_pkg::CMD_WRITE: begin
                unique case (item.reg_addr)
                    cia_pkg::REG_PRA:
                        pra_next = (item.write_data & ddra_reg) | (pra_reg & ~ddra_reg);
                    cia_pkg::REG_PRB:
                        prb_next = (item.write_data & ddrb_reg) | (prb_reg & ~ddrb_reg);
                    cia_pkg::REG_DDRA: ddra_next = item.write_data;
                    cia_pkg::REG_DDRB: ddrb_next = item.write_data;
                    cia_pkg::REG_TALO: begin
                        ta_next[7:0]       = item.write_data;
                        ta_latch_next[7:0] = item.write_data;
                    end
                    cia_pkg::REG_TAHI: begin
                        ta_next[15:8]       = item.write_data;
                        ta_latch_next[15:8] = item.write_data;
                    end
                    cia_pkg::REG_TBLO: begin
                        tb_next[7:0]       = item.write_data;
                        tb_latch_next[7:0] = item.write_data;
                    end
                    cia_pkg::REG_TBHI: begin
                        tb_next[15:8]       = item.write_data;
                        tb_latch_next[15:8] = item.write_data;
                    end
                    cia_pkg::REG_TENTHS, cia_pkg::REG_SECS,
                    cia_pkg::REG_MINS, cia_pkg::REG_HOURS:
                        tod_next[tod_idx] = item.write_data;
                    cia_pkg::REG_SDR: sdr_next = item.write_data;
                    cia_pkg::REG_ICR: begin
                        if (item.write_data[7]) begin
                            mask_next = mask_reg | item.write_data[6:0];
                        end else begin
                            mask_next = mask_reg & ~item.write_data[6:0];
                        end
                    end
                    cia_pkg::REG_CRA: begin
                        cra_next = item.write_data;
                        if (item.write_data[cia_pkg::CR_LOAD]) begin
                            ta_next = ta_latch_reg;
                        end
                    end
                    cia_pkg::REG_CRB: begin
                        crb_next = item.write_data;
                        if (item.write_data[cia_pkg::CR_LOAD]) begin
                            tb_next = tb_latch_reg;
                        end
                    end
                endcase
            end
            cia_pkg::CMD_TICK: begin
                if (ta_run) begin
                    ta_next = ta_under ? ta_latch_reg : ta_diff;
                end
                if (ta_under) begin
                    status_next[cia_pkg::ISR_TA] = 1'b1;
                    if (cra_reg[cia_pkg::CR_ONESHOT]) begin
                        cra_next[cia_pkg::CR_START] = 1'b0;
                    end
                    if (mask_reg[cia_pkg::ISR_TA]) begin
                        status_next[cia_pkg::ISR_IRQ] = 1'b1;
                        irq = 1'b1;
                    end
                end
                if (tb_run) begin
                    tb_next = tb_under ? tb_latch_reg : tb_diff;
                end
                if (tb_under) begin
                    status_next[cia_pkg::ISR_TB] = 1'b1;
                    if (crb_reg[cia_pkg::CR_ONESHOT]) begin
                        crb_next[cia_pkg::CR_START] = 1'b0;
                    end
                    if (mask_reg[cia_pkg::ISR_TB]) begin
                        status_next[cia_pkg::ISR_IRQ] = 1'b1;
                        irq = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign result.read_data  = rd;
    assign result.irq_raised = irq;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pra_reg      <= 8'h00;
            prb_reg      <= 8'hff;
            ddra_reg     <= 8'hff;
            ddrb_reg     <= 8'h00;
            ta_reg       <= 16'd0;
            tb_reg       <= 16'd0;
            ta_latch_reg <= 16'd0;
            tb_latch_reg <= 16'd0;
            for (int i = 0; i < 4; i++) begin
                tod_reg[i]       <= 8'h00;
                tod_latch_reg[i] <= 8'h00;
            end
            sdr_reg      <= 8'h00;
            mask_reg     <= 7'd0;
            cra_reg      <= 8'h00;
            crb_reg      <= 8'h00;
            status_reg   <= 8'h00;
            hold_reg     <= 1'b0;
        end else if (step_valid) begin
            pra_reg       <= pra_next;
            prb_reg       <= prb_next;
            ddra_reg      <= ddra_next;
            ddrb_reg      <= ddrb_next;
            ta_reg        <= ta_next;
            tb_reg        <= tb_next;
            ta_latch_reg  <= ta_latch_next;
            tb_latch_reg  <= tb_latch_next;
            tod_reg       <= tod_next;
            tod_latch_reg <= tod_latch_next;
            sdr_reg       <= sdr_next;
            mask_reg      <= mask_next;
            cra_reg       <= cra_next;
            crb_reg       <= crb_next;
            status_reg    <= status_next;
            hold_reg      <= hold_next;
        end
    end

endmodule

>>> hw/rtl/complex_interface_adapter.sv
// channel   dir   handshake          payload
// s_        in    s_valid/s_ready    s_data   (cia_pkg::cia_in_t)
// m_        out   m_valid/m_ready    m_data   (cia_pkg::cia_out_t)
//
// one beat per cycle sustained while m_ is not stalled; a beat passes through the input register
// and then the output register, where its result beat waits for m_ready.
// all register, timer and key state updates in the cycle a beat leaves the input register.
// aresetn is synchronous: all CIA state returns to power-on values, both stages empty.
// s_ready stays high while m_ is stalled until both stages hold a beat.
module complex_interface_adapter (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cia_pkg::cia_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output cia_pkg::cia_out_t m_data
);

    logic              in_valid_reg;
    cia_pkg::cia_in_t  in_data_reg;
    logic              m_valid_reg;
    cia_pkg::cia_out_t m_data_reg;
    logic              advance;
    logic [7:0]        pra;
    logic [7:0]        scan_data;
    cia_pkg::cia_out_t result;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    cia_keys u_keys (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_valid (advance),
        .item       (in_data_reg),
        .pra        (pra),
        .scan_data  (scan_data)
    );

    cia_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_valid (advance),
        .item       (in_data_reg),
        .scan_data  (scan_data),
        .pra        (pra),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            m_data_reg <= result;
        end
    end

endmodule

>>> bench/cia_checker.sv
module cia_checker
    import cia_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  cia_in_t  s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  cia_out_t m_data,
    output int       fail_count,
    output int       replies_left,
    output int       replies_seen,
    output int       irq_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0] run_regs [16];
    logic [7:0] latch_regs [16];
    logic [7:0] key_rows [8];
    logic [7:0] int_status;
    logic       tod_held;
    logic       tick_irq;

    cia_out_t replies_due [$];

    function automatic void clear_adapter();
        for (int i = 0; i < 16; i++) begin
            run_regs[i] = 8'h00;
            latch_regs[i] = 8'h00;
        end
        for (int i = 0; i < 8; i++) begin
            key_rows[i] = 8'hff;
        end
        run_regs[REG_DDRA] = 8'hff;
        run_regs[REG_PRB] = 8'hff;
        int_status = 8'h00;
        tod_held = 1'b0;
    endfunction

    // rows of every column whose port A bit is low, zero bit = pressed
    function automatic logic [7:0] scan_matrix();
        logic [7:0] v;
        v = 8'hff;
        for (int i = 0; i < KEY_COLUMNS && i < 8; i++) begin
            if (!run_regs[REG_PRA][i]) v &= key_rows[i];
        end
        return v;
    endfunction

    function automatic logic count_down(logic [3:0] lo, logic [3:0] cr, int unsigned flag,
                                        logic [15:0] n);
        logic [15:0] t;
        logic [15:0] u;
        t = {run_regs[4'(lo + 1)], run_regs[lo]};
        u = t - n;
        run_regs[lo] = u[7:0];
        run_regs[4'(lo + 1)] = u[15:8];
        if (n <= t) return 1'b0;
        int_status[flag] = 1'b1;
        if (run_regs[cr][CR_ONESHOT]) run_regs[cr][CR_START] = 1'b0;
        if (run_regs[REG_ICR][flag]) begin
            int_status[ISR_IRQ] = 1'b1;
            tick_irq = 1'b1;
        end
        run_regs[lo] = latch_regs[lo];
        run_regs[4'(lo + 1)] = latch_regs[4'(lo + 1)];
        return 1'b1;
    endfunction

    function automatic logic [7:0] bus_read(logic [3:0] r);
        logic [7:0] v;
        case (r)
            REG_ICR: begin
                v = int_status;
                int_status = 8'h00;
            end
            REG_PRB: v = scan_matrix();
            REG_HOURS: begin
                for (int i = REG_TENTHS; i <= REG_HOURS; i++) latch_regs[i] = run_regs[i];
                tod_held = 1'b1;
                v = latch_regs[REG_HOURS];
            end
            REG_MINS, REG_SECS: v = tod_held ? latch_regs[r] : run_regs[r];
            REG_TENTHS: begin
                v = tod_held ? latch_regs[r] : run_regs[r];
                tod_held = 1'b0;
            end
            default: v = run_regs[r];
        endcase
        return v;
    endfunction

    function automatic void bus_write(logic [3:0] r, logic [7:0] v);
        logic [7:0] dir;
        logic [3:0] lo;
        case (r)
            REG_PRA, REG_PRB: begin
                dir = run_regs[4'(r + 2)];
                run_regs[r] = (v & dir) | (run_regs[r] & ~dir);
            end
            REG_TALO, REG_TAHI, REG_TBLO, REG_TBHI: begin
                run_regs[r] = v;
                latch_regs[r] = v;
            end
            REG_ICR: begin
                if (v[7]) run_regs[REG_ICR] |= (v & 8'h7f);
                else run_regs[REG_ICR] &= ~(v & 8'h7f);
            end
            REG_CRA, REG_CRB: begin
                run_regs[r] = v;
                if (v[CR_LOAD]) begin
                    lo = (r == REG_CRA) ? REG_TALO : REG_TBLO;
                    run_regs[lo] = latch_regs[lo];
                    run_regs[4'(lo + 1)] = latch_regs[4'(lo + 1)];
                end
            end
            default: run_regs[r] = v;
        endcase
    endfunction

    function automatic logic timer_tick(logic [15:0] ticks);
        logic [7:0] cra;
        logic [7:0] crb;
        logic [15:0] n;
        logic ta_under;
        cra = run_regs[REG_CRA];
        crb = run_regs[REG_CRB];
        ta_under = 1'b0;
        tick_irq = 1'b0;
        if (cra[CR_START] && !cra[CRA_CNT])
            ta_under = count_down(REG_TALO, REG_CRA, ISR_TA, ticks);
        if (crb[CR_START]) begin
            n = 16'h0000;
            // crb bits 6..5 pick what timer b counts
            if (crb[6:5] == CRB_MODE_CLK) n = ticks;
            else if (crb[6:5] == CRB_MODE_TA) n = {15'd0, ta_under};
            void'(count_down(REG_TBLO, REG_CRB, ISR_TB, n));
        end
        return tick_irq;
    endfunction

    function automatic cia_out_t apply_beat(cia_in_t b);
        cia_out_t o;
        o = '0;
        case (b.command)
            CMD_READ: o.read_data = bus_read(b.reg_addr);
            CMD_WRITE: bus_write(b.reg_addr, b.write_data);
            CMD_TICK: o.irq_raised = timer_tick(b.elapsed_ticks);
            CMD_KEY_DOWN: begin
                if (b.key_column < KEY_COLUMNS) key_rows[b.key_column][b.key_row] = 1'b0;
            end
            CMD_KEY_UP: begin
                if (b.key_column < KEY_COLUMNS) key_rows[b.key_column][b.key_row] = 1'b1;
            end
            default: ;
        endcase
        return o;
    endfunction

    always @(posedge aclk) begin : watch
        cia_out_t want;
        if (!aresetn) begin
            clear_adapter();
            replies_due.delete();
            fail_count = 0;
            replies_seen = 0;
            irq_seen = 0;
        end else begin
            // results first: a beat accepted now cannot come out at this edge
            if (m_valid && m_ready) begin
                replies_seen++;
                if (m_data.irq_raised) irq_seen++;
                if (replies_due.size() == 0) begin
                    $error("result beat with no pending expectation: read_data %02h irq %0b",
                           m_data.read_data, m_data.irq_raised);
                    fail_count++;
                end else begin
                    want = replies_due.pop_front();
                    if (m_data.read_data !== want.read_data) begin
                        $error("read_data: expected %02h, actual %02h",
                               want.read_data, m_data.read_data);
                        fail_count++;
                    end
                    if (m_data.irq_raised !== want.irq_raised) begin
                        $error("irq_raised: expected %0b, actual %0b",
                               want.irq_raised, m_data.irq_raised);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) replies_due.push_back(apply_beat(s_data));
        end
        replies_left = replies_due.size();
    end

endmodule

>>> bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cia_pkg::*;

    localparam int unsigned BEAT_TARGET = 1650;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PHASES = 8;
    localparam int unsigned DRAIN_CYCLES = 6;
    // command codes the block does not define
    localparam int unsigned CMD_SPARE_LO = 5;
    localparam int unsigned CMD_SPARE_HI = 7;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    cia_in_t  s_data;
    logic     m_valid;
    logic     m_ready = 1'b0;
    cia_out_t m_data;

    int fail_count;
    int replies_left;
    int replies_seen;
    int irq_seen;
    int beats_sent = 0;
    int stall_left = 0;
    int cycle_count = 0;
    bit idle_on = 1'b1;

    complex_interface_adapter dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    cia_checker chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .fail_count   (fail_count),
        .replies_left (replies_left),
        .replies_seen (replies_seen),
        .irq_seen     (irq_seen)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // result side back-pressure in bursts of random length while idle_on is set
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 11);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("complex_interface_adapter test failed");
        $finish;
    end

    function automatic cia_in_t noise_beat();
        cia_in_t b;
        b.command = 3'($urandom_range(0, 7));
        b.reg_addr = 4'($urandom_range(0, 15));
        b.write_data = 8'($urandom_range(0, 255));
        b.elapsed_ticks = 16'($urandom_range(0, 65535));
        b.key_column = 3'($urandom_range(0, 7));
        b.key_row = 3'($urandom_range(0, 7));
        return b;
    endfunction

    task automatic send_beat(cia_in_t b);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= b;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    task automatic reg_read(logic [3:0] r);
        cia_in_t b;
        b = noise_beat();
        b.command = CMD_READ;
        b.reg_addr = r;
        send_beat(b);
    endtask

    task automatic reg_write(logic [3:0] r, logic [7:0] v);
        cia_in_t b;
        b = noise_beat();
        b.command = CMD_WRITE;
        b.reg_addr = r;
        b.write_data = v;
        send_beat(b);
    endtask

    task automatic tick_beat(logic [15:0] n);
        cia_in_t b;
        b = noise_beat();
        b.command = CMD_TICK;
        b.elapsed_ticks = n;
        send_beat(b);
    endtask

    task automatic key_beat(bit down, logic [2:0] col, logic [2:0] row);
        cia_in_t b;
        b = noise_beat();
        b.command = down ? CMD_KEY_DOWN : CMD_KEY_UP;
        b.key_column = col;
        b.key_row = row;
        send_beat(b);
    endtask

    function automatic logic [15:0] some_ticks();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) return 16'($urandom_range(0, 64));
        if (pick < 9) return 16'($urandom_range(0, 4095));
        return 16'($urandom_range(0, 65535));
    endfunction

    // load a timer latch, start it, and let it run down over a few ticks
    task automatic timer_run();
        bit use_b;
        logic [3:0] lo_reg;
        logic [3:0] cr_reg;
        logic [7:0] ctrl;
        logic [7:0] cra;
        use_b = 1'($urandom_range(0, 1));
        lo_reg = use_b ? REG_TBLO : REG_TALO;
        cr_reg = use_b ? REG_CRB : REG_CRA;
        if ($urandom_range(0, 2) == 0) reg_write(REG_ICR, 8'($urandom_range(0, 255)));
        reg_write(lo_reg, 8'($urandom_range(0, 255)));
        reg_write(4'(lo_reg + 1), ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'h00);
        ctrl = 8'($urandom_range(0, 255));
        ctrl[CR_START] = 1'b1;
        ctrl[CR_LOAD] = 1'b1;
        if (!use_b) begin
            ctrl[CRA_CNT] = ($urandom_range(0, 5) == 0);
        end else if ($urandom_range(0, 3) != 0) begin
            ctrl[6:5] = $urandom_range(0, 1) ? CRB_MODE_TA : CRB_MODE_CLK;
        end
        if (use_b && ctrl[6:5] == CRB_MODE_TA) begin
            cra = 8'($urandom_range(0, 255));
            cra[CR_START] = 1'b1;
            cra[CRA_CNT] = 1'b0;
            reg_write(REG_CRA, cra);
        end
        reg_write(cr_reg, ctrl);
        repeat ($urandom_range(2, 8)) begin
            tick_beat(some_ticks());
            if ($urandom_range(0, 3) == 0) reg_read(REG_ICR);
        end
        reg_read(REG_ICR);
        reg_read(lo_reg);
    endtask

    // freeze the clock registers, change them underneath, read back, release
    task automatic tod_run();
        reg_read(REG_HOURS);
        if ($urandom_range(0, 1)) reg_write(4'($urandom_range(REG_TENTHS, REG_HOURS)),
                                            8'($urandom_range(0, 255)));
        reg_read(REG_MINS);
        reg_read(REG_SECS);
        if ($urandom_range(0, 1)) reg_write(4'($urandom_range(REG_TENTHS, REG_HOURS)),
                                            8'($urandom_range(0, 255)));
        reg_read(REG_TENTHS);
        reg_read(4'($urandom_range(REG_TENTHS, REG_MINS)));
    endtask

    task automatic key_run();
        repeat ($urandom_range(1, 4)) key_beat(1'b1, 3'($urandom_range(0, 7)),
                                               3'($urandom_range(0, 7)));
        if ($urandom_range(0, 3) == 0) reg_write(REG_DDRA, 8'($urandom_range(0, 255)));
        reg_write(REG_PRA, 8'($urandom_range(0, 255)));
        reg_read(REG_PRB);
        repeat ($urandom_range(1, 4)) key_beat(1'b0, 3'($urandom_range(0, 7)),
                                               3'($urandom_range(0, 7)));
        reg_read(REG_PRB);
    endtask

    task automatic single_beat();
        cia_in_t b;
        int unsigned pick;
        b = noise_beat();
        pick = $urandom_range(0, 99);
        if (pick < 28) b.command = CMD_READ;
        else if (pick < 58) b.command = CMD_WRITE;
        else if (pick < 83) b.command = CMD_TICK;
        else if (pick < 90) b.command = CMD_KEY_DOWN;
        else if (pick < 96) b.command = CMD_KEY_UP;
        else b.command = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        if (b.command == CMD_TICK && $urandom_range(0, 3) != 0) b.elapsed_ticks = some_ticks();
        send_beat(b);
    endtask

    initial begin
        cia_in_t b;
        int unsigned pick;
        int unsigned phase_end;
        s_valid <= 1'b0;
        s_data <= '0;
        aresetn <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: keyboard scan, timer underflows, clock hold and release, port B write, spare command
        reg_read(REG_PRB);
        key_beat(1'b1, 3'd0, 3'd0);
        key_beat(1'b1, 3'd7, 3'd7);
        reg_read(REG_PRB);
        reg_write(REG_PRA, 8'hfe);
        reg_read(REG_PRB);
        key_beat(1'b0, 3'd0, 3'd0);
        reg_write(REG_ICR, 8'h80 | 8'(1 << ISR_TA) | 8'(1 << ISR_TB));
        reg_write(REG_TALO, 8'h02);
        reg_write(REG_TAHI, 8'h00);
        reg_write(REG_TBLO, 8'h00);
        reg_write(REG_TBHI, 8'h00);
        reg_write(REG_CRA, 8'(1 << CR_START) | 8'(1 << CR_ONESHOT) | 8'(1 << CR_LOAD));
        reg_write(REG_CRB, {1'b0, CRB_MODE_TA, 5'b0} | 8'(1 << CR_START) | 8'(1 << CR_LOAD));
        // timer a underflows and timer b counts that underflow down from zero
        tick_beat(16'hffff);
        reg_read(REG_ICR);
        reg_read(REG_ICR);
        reg_read(REG_HOURS);
        reg_write(REG_TENTHS, 8'h55);
        reg_read(REG_TENTHS);
        reg_read(REG_TENTHS);
        reg_write(REG_DDRB, 8'h0f);
        reg_write(REG_PRB, 8'haa);
        reg_write(REG_ICR, 8'h7f);
        tick_beat(16'h0000);
        b = noise_beat();
        b.command = 3'(CMD_SPARE_HI);
        send_beat(b);

        for (int p = 0; p < PHASES; p++) begin
            // back-to-back stretches with no idles or stalls in the middle and at the end
            idle_on = (p != 3) && (p != PHASES - 1);
            phase_end = beats_sent + (BEAT_TARGET - beats_sent) / (PHASES - p);
            while (beats_sent < phase_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 20) timer_run();
                else if (pick < 27) tod_run();
                else if (pick < 34) key_run();
                else single_beat();
            end
        end
        s_valid <= 1'b0;

        do @(posedge aclk); while (replies_left != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d beats of reads, writes, ticks and key events", beats_sent);
        $display("checked %0d result beats, %0d with a timer interrupt", replies_seen, irq_seen);
        if (fail_count == 0) begin
            $display("complex_interface_adapter test passed");
        end else begin
            $display("complex_interface_adapter test failed");
        end
        $finish;
    end

endmodule
